### design/adtf_pkg.sv
// Package for the ASCII decimal to fixed point converter.
// Holds format constants, character codes, the power-of-ten table and the FSM/status types.
// No dependencies.
package adtf_pkg;

  // Fixed point format
  localparam int FRAC_DIGITS = 6;                  // fraction digits kept
  localparam int FRAC_BITS   = 16;                 // fraction bits of the result
  localparam int VALUE_W     = 32;                 // result width
  localparam int WHOLE_BITS  = VALUE_W - 1 - FRAC_BITS;
  localparam logic [WHOLE_BITS-1:0] WHOLE_MAX = '1;

  // Powers of ten, indexed by fraction digit count
  localparam logic [31:0] POW10 [8] = '{
    32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000, 32'd1000000, 32'd10000000
  };

  // Datapath widths
  localparam int FRAC_ACC_W  = $clog2(POW10[FRAC_DIGITS]);
  localparam int FRAC_CNT_W  = $clog2(FRAC_DIGITS + 1);
  localparam int ACC_W       = (WHOLE_BITS > FRAC_ACC_W) ? WHOLE_BITS : FRAC_ACC_W;
  localparam int UNIT_W      = ACC_W + 4;
  localparam int DEN_W       = FRAC_ACC_W + 1;
  localparam int DIV_CNT_W   = $clog2(FRAC_BITS);

  // Character codes
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    STAT_OK  = 2'd0,
    STAT_BAD = 2'd1,
    STAT_OVF = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHAR,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

### design/ascii_decimal_to_fixed_top.sv
// ASCII decimal string to signed fixed point converter, top level.
// Takes one character per transaction; an optional leading minus, whole digits, one optional
// point and fraction digits. Each character is captured, then parsed in one multiply-by-ten
// step of the shared shift-add unit. After the last character, the restoring divider scales the
// fraction by 10^count one quotient bit per cycle (Q15.16 result at the default). The result
// sits in an output register; the next string's first character is taken while it waits.
// Status: 0 ok, 1 invalid character (value 0), 2 whole part saturated.
// Depends on adtf_pkg.
module ascii_decimal_to_fixed_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_character,
  input  logic                         in_last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [adtf_pkg::VALUE_W-1:0] out_value,
  output logic [1:0]                   out_status
);
  import adtf_pkg::*;

  state_t state_r, state_nxt;

  logic [7:0]                  char_r;
  logic                        last_r;
  logic                        first_r, first_nxt;
  logic                        neg_r, neg_nxt;
  logic                        seen_pt_r, seen_pt_nxt;
  logic [WHOLE_BITS-1:0]       whole_r, whole_nxt;
  logic [FRAC_ACC_W-1:0]       frac_r, frac_nxt;
  logic [FRAC_CNT_W-1:0]       fcnt_r, fcnt_nxt;
  logic                        bad_r, bad_nxt;
  logic                        ovf_r, ovf_nxt;

  logic [DEN_W-1:0]            rem_r, rem_nxt;
  logic [DEN_W-1:0]            den_r, den_nxt;
  logic [FRAC_BITS-1:0]        quo_r, quo_nxt;
  logic [DIV_CNT_W-1:0]        dcnt_r, dcnt_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]          out_value_r, out_value_nxt;
  status_t                     out_status_r, out_status_nxt;

  logic                        in_fire;
  logic                        is_digit;
  logic [3:0]                  digit;
  logic [UNIT_W-1:0]           mul_op;
  logic [UNIT_W-1:0]           mul_res;
  logic [DEN_W+1:0]            div_diff;
  logic [VALUE_W-1:0]          mag;
  logic                        can_out;

  assign in_ready   = (state_r == ST_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  // Shared multiply-by-ten unit: 10x + d as two shifts and adds
  assign is_digit = (char_r >= CH_ZERO) && (char_r <= CH_NINE);
  assign digit    = 4'(char_r - CH_ZERO);
  assign mul_op   = seen_pt_r ? UNIT_W'(frac_r) : UNIT_W'(whole_r);
  assign mul_res  = (mul_op << 3) + (mul_op << 1) + UNIT_W'(digit);

  // Restoring divider step: shift remainder, try subtracting the denominator
  assign div_diff = {1'b0, rem_r, 1'b0} - {2'b00, den_r};

  // Magnitude: fraction quotient is always below one
  assign mag     = {1'b0, whole_r, quo_r};
  assign can_out = !out_valid_r || out_ready;

  // Next state and datapath
  always_comb begin
    state_nxt      = state_r;
    first_nxt      = first_r;
    neg_nxt        = neg_r;
    seen_pt_nxt    = seen_pt_r;
    whole_nxt      = whole_r;
    frac_nxt       = frac_r;
    fcnt_nxt       = fcnt_r;
    bad_nxt        = bad_r;
    ovf_nxt        = ovf_r;
    rem_nxt        = rem_r;
    den_nxt        = den_r;
    quo_nxt        = quo_r;
    dcnt_nxt       = dcnt_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_CHAR;
      end
      ST_CHAR: begin
        // Parse one character into the accumulators
        first_nxt = 1'b0;
        if (!bad_r) begin
          if (first_r && char_r == CH_MINUS) begin
            neg_nxt = 1'b1;
          end else if (char_r == CH_POINT && !seen_pt_r) begin
            seen_pt_nxt = 1'b1;
          end else if (is_digit) begin
            if (seen_pt_r) begin
              if (fcnt_r < FRAC_CNT_W'(FRAC_DIGITS)) begin
                frac_nxt = mul_res[FRAC_ACC_W-1:0];
                fcnt_nxt = fcnt_r + 1'b1;
              end
            end else if (mul_res > UNIT_W'(WHOLE_MAX)) begin
              whole_nxt = WHOLE_MAX;
              ovf_nxt   = 1'b1;
            end else begin
              whole_nxt = mul_res[WHOLE_BITS-1:0];
            end
          end else begin
            bad_nxt = 1'b1;
          end
        end
        state_nxt = last_r ? ST_LOAD : ST_IDLE;
      end
      ST_LOAD: begin
        // Set up fraction scaling by 10^count
        rem_nxt   = DEN_W'(frac_r);
        den_nxt   = DEN_W'(POW10[3'(fcnt_r)]);
        quo_nxt   = '0;
        dcnt_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (!div_diff[DEN_W+1]) begin
          rem_nxt = div_diff[DEN_W-1:0];
          quo_nxt = {quo_r[FRAC_BITS-2:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[DEN_W-2:0], 1'b0};
          quo_nxt = {quo_r[FRAC_BITS-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == DIV_CNT_W'(FRAC_BITS - 1)) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // Hold until the output register is free, then clear for the next string
        if (can_out) begin
          out_valid_nxt = 1'b1;
          if (bad_r) begin
            out_value_nxt  = '0;
            out_status_nxt = STAT_BAD;
          end else begin
            out_value_nxt  = neg_r ? (VALUE_W'(0) - mag) : mag;
            out_status_nxt = ovf_r ? STAT_OVF : STAT_OK;
          end
          first_nxt   = 1'b1;
          neg_nxt     = 1'b0;
          seen_pt_nxt = 1'b0;
          whole_nxt   = '0;
          frac_nxt    = '0;
          fcnt_nxt    = '0;
          bad_nxt     = 1'b0;
          ovf_nxt     = 1'b0;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control and parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      first_r     <= 1'b1;
      neg_r       <= 1'b0;
      seen_pt_r   <= 1'b0;
      whole_r     <= '0;
      frac_r      <= '0;
      fcnt_r      <= '0;
      bad_r       <= 1'b0;
      ovf_r       <= 1'b0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      first_r     <= first_nxt;
      neg_r       <= neg_nxt;
      seen_pt_r   <= seen_pt_nxt;
      whole_r     <= whole_nxt;
      frac_r      <= frac_nxt;
      fcnt_r      <= fcnt_nxt;
      bad_r       <= bad_nxt;
      ovf_r       <= ovf_nxt;
      dcnt_r      <= dcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      char_r <= in_character;
      last_r <= in_last;
    end
    rem_r        <= rem_nxt;
    den_r        <= den_nxt;
    quo_r        <= quo_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  // Divider remainder stays below the denominator
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < den_r))
    else $error("divider remainder out of range");

  // Fraction digit count never passes its limit
  a_fcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= FRAC_CNT_W'(FRAC_DIGITS))
    else $error("fraction digit count overrun");

  // Accepted character is parsed in the next cycle
  a_fire_char: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_CHAR))
    else $error("accepted character not parsed");

  // Finishing a string loads the output and rearms the parser
  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && can_out) |=> (out_valid_r && first_r && state_r == ST_IDLE))
    else $error("result not delivered or state not cleared");

endmodule

### tb/ascii_decimal_to_fixed_top_test.sv
// Testbench for ascii_decimal_to_fixed_top: streams number strings and checks each result.
// Checks against a local parser of the string and randomizes idling on both channels.
// Depends on adtf_pkg and the ascii_decimal_to_fixed_top RTL.
module ascii_decimal_to_fixed_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import adtf_pkg::*;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    status_t                   status;
  } fixed_result_t;

  logic                      clk;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [7:0]                in_character = 8'h00;
  logic                      in_last = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [VALUE_W-1:0] out_value;
  logic [1:0]                out_status;

  // Parser state mirrored from the block
  logic        parse_first = 1'b1;
  logic        parse_neg = 1'b0;
  logic        parse_point = 1'b0;
  int unsigned parse_whole = 0;
  int unsigned parse_frac = 0;
  int unsigned parse_fcnt = 0;
  logic        parse_bad = 1'b0;
  logic        parse_ovf = 1'b0;

  fixed_result_t expected_results[$];
  int            error_count = 0;
  int            char_count = 0;
  bit            no_idle = 1'b0;

  ascii_decimal_to_fixed_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_character (in_character),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value    (out_value),
    .out_status   (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

  // Stall the result channel at random, except during the no-idle stretch
  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(0, 99) >= 11);
  end

  // Compare each result transaction with the oldest expected result
  always @(posedge clk) begin
    fixed_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result value %h status %0d", $time, out_value, out_status);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_value !== want.value) begin
          $display("%0t: value expected %h actual %h", $time, want.value, out_value);
          error_count++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          error_count++;
        end
      end
    end
  end

  // Advance the parser by one character; on the last one queue the converted value
  task automatic parse_char(input logic [7:0] ch, input logic lst);
    logic          was_first;
    int unsigned   wide;
    longint unsigned scaled;
    logic [31:0]   mag;
    fixed_result_t res;
    was_first   = parse_first;
    parse_first = 1'b0;
    if (!parse_bad) begin
      if (was_first && ch == CH_MINUS) begin
        parse_neg = 1'b1;
      end else if (ch == CH_POINT && !parse_point) begin
        parse_point = 1'b1;
      end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
        if (parse_point) begin
          // drop fraction digits past the kept count
          if (parse_fcnt < FRAC_DIGITS) begin
            parse_frac = parse_frac * 10 + (ch - CH_ZERO);
            parse_fcnt++;
          end
        end else begin
          wide = parse_whole * 10 + (ch - CH_ZERO);
          if (wide > WHOLE_MAX) begin
            parse_whole = WHOLE_MAX;
            parse_ovf   = 1'b1;
          end else begin
            parse_whole = wide;
          end
        end
      end else begin
        parse_bad = 1'b1;
      end
    end
    if (lst) begin
      if (parse_bad) begin
        res.value  = '0;
        res.status = STAT_BAD;
      end else begin
        scaled     = (longint'(parse_frac) << FRAC_BITS) / POW10[parse_fcnt];
        mag        = (parse_whole << FRAC_BITS) + scaled[31:0];
        res.value  = parse_neg ? -mag : mag;
        res.status = parse_ovf ? STAT_OVF : STAT_OK;
      end
      expected_results = {expected_results, res};
      parse_first = 1'b1;
      parse_neg   = 1'b0;
      parse_point = 1'b0;
      parse_whole = 0;
      parse_frac  = 0;
      parse_fcnt  = 0;
      parse_bad   = 1'b0;
      parse_ovf   = 1'b0;
    end
  endtask

  // Send one character transaction; valid stays high after acceptance until the next call
  task automatic send_char(input logic [7:0] ch, input logic lst);
    while (!no_idle && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_character <= ch;
    in_last      <= lst;
    do @(posedge clk); while (!in_ready);
    parse_char(ch, lst);
    char_count++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], i == s.len() - 1);
    end
  endtask

  task automatic send_bytes(input logic [7:0] chars[$]);
    for (int i = 0; i < chars.size(); i++) begin
      send_char(chars[i], i == chars.size() - 1);
    end
  endtask

  // Build a well-formed number: optional minus, whole digits, optional point and fraction
  task automatic send_number();
    logic [7:0] chars[$];
    int         n_whole;
    int         n_frac;
    if ($urandom_range(0, 9) < 4) chars = {chars, CH_MINUS};
    // lean on long whole parts now and then to reach saturation
    n_whole = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 5);
    repeat (n_whole) chars = {chars, 8'(CH_ZERO + $urandom_range(0, 9))};
    if ($urandom_range(0, 9) < 7) begin
      chars = {chars, CH_POINT};
      n_frac = $urandom_range(0, 9);
      repeat (n_frac) chars = {chars, 8'(CH_ZERO + $urandom_range(0, 9))};
    end
    if (chars.size() == 0) chars = {chars, 8'(CH_ZERO + $urandom_range(0, 9))};
    send_bytes(chars);
  endtask

  task automatic test_directed();
    send_text("-");
    send_text(".");
    send_text("-9.5");
    send_text("40000");
    send_text(".9999999");
    send_text("1-");
    send_text("..");
    // invalid first character, rest ignored
    send_bytes('{8'h00, 8'hFF});
  endtask

  task automatic test_wellformed();
    int stop_at;
    stop_at = char_count + 320;
    while (char_count < stop_at) send_number();
  endtask

  task automatic test_back_to_back();
    int stop_at;
    no_idle = 1'b1;
    stop_at = char_count + 80;
    while (char_count < stop_at) send_number();
    no_idle = 1'b0;
  endtask

  // Broken strings: misplaced signs and points, arbitrary bytes
  task automatic test_noise();
    logic [7:0] chars[$];
    int         stop_at;
    stop_at = char_count + 100;
    while (char_count < stop_at) begin
      chars.delete();
      repeat ($urandom_range(1, 8)) begin
        case ($urandom_range(0, 3))
          0: chars = {chars, 8'($urandom_range(0, 255))};
          1: chars = {chars, CH_MINUS};
          2: chars = {chars, CH_POINT};
          default: chars = {chars, 8'(CH_ZERO + $urandom_range(0, 9))};
        endcase
      end
      send_bytes(chars);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_wellformed();
    test_back_to_back();
    test_noise();
    in_valid <= 1'b0;
    // drain the outstanding results, then give the block time to misbehave
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
design/adtf_pkg.sv
design/ascii_decimal_to_fixed_top.sv
tb/ascii_decimal_to_fixed_top_test.sv
